// ===== src/cas_pkg.sv =====
// ----------------------------------------------------------------------------
// cas_pkg: shared types and constants
// Slot count, field widths, function and status codes, lane and verdict
// structs for the reader/writer lock table.
// ----------------------------------------------------------------------------
package cas_pkg;

  // slots per request word (ports are fixed to this count)
  localparam int SLOTS   = 4;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int SCNT_W  = $clog2(SLOTS + 1);
  localparam int N_W     = 3;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int FSLOT_W = 2;

  // reader count per entry
  localparam int CNT_W   = 8;
  localparam int CNT_MAX = 255;

  // parameter defaults
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int ID_BITS_DEF       = 16;

  // function codes (code 3 behaves as check)
  localparam logic [FUNC_W-1:0] FN_CHECK   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ACQUIRE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_CONFLICT = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOROOM   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTHELD  = 2'd3;

  // what one lane found in the table
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] cnt;
  } lane_res_t;

  // merged outcome of one request
  typedef struct packed {
    logic               granted;
    logic [STAT_W-1:0]  status;
    logic [FSLOT_W-1:0] fault_slot;
  } verdict_t;

endpackage

// ===== src/component_access_scoreboard.sv =====
// ----------------------------------------------------------------------------
// component_access_scoreboard: reader/writer lock table
// Associative table of held resource IDs with per-entry reader counts
// (count zero = one writer). Words check, try-acquire or release up to four
// resources at once, all or nothing.
//
//   channel | ports                                   | flow control
//   --------+-----------------------------------------+--------------------
//   input   | in_func, in_n_components, in_res_id_*,  | start / busy
//           | in_wr_*                                 |
//   result  | out_granted, out_status, out_fault_slot | out_valid strobe
//
// Sequence: a word taken at an edge is evaluated in the next cycle; the four
// slot lanes look up the table in parallel and the merge stage forms the
// verdict, which shows on the result ports in the following cycle for one cycle.
// An applied acquire or release then walks its slots one per cycle through
// the table, so busy stays high through evaluation and until the last slot in
// use is committed (commit only when applied), otherwise through evaluation.
// Reset (rst_n low, synchronous) empties the table at once; no sweep.
// The receiver cannot stall; a result is never held back.
// ----------------------------------------------------------------------------
module component_access_scoreboard #(
  parameter int TABLE_ENTRIES = cas_pkg::TABLE_ENTRIES_DEF,
  parameter int ID_BITS       = cas_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input word
  input  logic                         start,
  output logic                         busy,
  input  logic [cas_pkg::FUNC_W-1:0]   in_func,
  input  logic [cas_pkg::N_W-1:0]      in_n_components,
  input  logic [ID_BITS-1:0]           in_res_id_0,
  input  logic [ID_BITS-1:0]           in_res_id_1,
  input  logic [ID_BITS-1:0]           in_res_id_2,
  input  logic [ID_BITS-1:0]           in_res_id_3,
  input  logic                         in_wr_0,
  input  logic                         in_wr_1,
  input  logic                         in_wr_2,
  input  logic                         in_wr_3,
  // result word
  output logic                         out_valid,
  output logic                         out_granted,
  output logic [cas_pkg::STAT_W-1:0]   out_status,
  output logic [cas_pkg::FSLOT_W-1:0]  out_fault_slot
);

  localparam int S     = cas_pkg::SLOTS;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int UW    = $clog2(TABLE_ENTRIES + 1);

  // sequencer
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EVAL   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [cas_pkg::SLOT_W-1:0] slot_r, slot_nxt;

  // captured word
  logic [cas_pkg::FUNC_W-1:0] func_r;
  logic [cas_pkg::SCNT_W-1:0] n_r;
  logic [ID_BITS-1:0]         ids_r [S];
  logic [S-1:0]               wr_r;
  logic [ID_BITS-1:0]         ids_in [S];
  logic                       accept;

  // table
  logic [TABLE_ENTRIES-1:0]   valid_r, valid_nxt;
  logic [ID_BITS-1:0]         id_r  [TABLE_ENTRIES];
  logic [cas_pkg::CNT_W-1:0]  cnt_r [TABLE_ENTRIES];
  logic [UW-1:0]              used_r, used_nxt;

  // lanes and merge
  cas_pkg::lane_res_t         lane_res [S];
  logic [IDX_W-1:0]           lane_idx [S];
  cas_pkg::verdict_t          verdict;

  // commit path
  logic                       sel_hit;
  logic [IDX_W-1:0]           sel_idx;
  logic [cas_pkg::CNT_W-1:0]  sel_cnt;
  logic                       sel_add;
  logic [TABLE_ENTRIES-1:0]   free_vec, free_low;
  logic [IDX_W-1:0]           free_idx;
  logic                       tw_en;
  logic [IDX_W-1:0]           tw_idx;
  logic [cas_pkg::CNT_W-1:0]  tw_cnt;
  logic                       last_slot;
  logic                       applies;

  // result register
  logic                       out_valid_r;
  cas_pkg::verdict_t          out_r;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign ids_in[0] = in_res_id_0;
  assign ids_in[1] = in_res_id_1;
  assign ids_in[2] = in_res_id_2;
  assign ids_in[3] = in_res_id_3;

  // capture the word; slot count clipped to the slot total
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      n_r    <= (in_n_components > cas_pkg::N_W'(S)) ? cas_pkg::SCNT_W'(S)
                                                    : cas_pkg::SCNT_W'(in_n_components);
      for (int k = 0; k < S; k++) ids_r[k] <= ids_in[k];
      wr_r   <= {in_wr_3, in_wr_2, in_wr_1, in_wr_0};
    end
  end

  // one lookup lane per slot; lanes stay live during commit so each step
  // sees the table as left by the step before
  for (genvar k = 0; k < S; k++) begin : g_lane
    cas_lane #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ID_BITS       (ID_BITS)
    ) u_lane (
      .id        (ids_r[k]),
      .tbl_valid (valid_r),
      .tbl_id    (id_r),
      .tbl_cnt   (cnt_r),
      .res       (lane_res[k]),
      .idx       (lane_idx[k])
    );
  end

  cas_merge #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ID_BITS       (ID_BITS)
  ) u_merge (
    .func    (func_r),
    .n       (n_r),
    .ids     (ids_r),
    .wr      (wr_r),
    .lane    (lane_res),
    .used    (used_r),
    .verdict (verdict)
  );

  // lowest free entry for a new ID
  assign free_vec = ~valid_r;
  assign free_low = free_vec & (~free_vec + TABLE_ENTRIES'(1));

  always_comb begin
    free_idx = '0;
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      if (free_low[e]) free_idx = free_idx | IDX_W'(e);
    end
  end

  assign sel_hit   = lane_res[slot_r].hit;
  assign sel_idx   = lane_idx[slot_r];
  assign sel_cnt   = lane_res[slot_r].cnt;
  assign sel_add   = !wr_r[slot_r];
  assign last_slot = (cas_pkg::SCNT_W'(slot_r) + cas_pkg::SCNT_W'(1) == n_r);
  assign applies   = verdict.granted && (n_r != '0)
                  && (func_r == cas_pkg::FN_ACQUIRE || func_r == cas_pkg::FN_RELEASE);

  // one slot applied per commit cycle, in slot order
  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    tw_en     = 1'b0;
    tw_idx    = sel_idx;
    tw_cnt    = sel_cnt;
    if (state_r == S_COMMIT) begin
      if (func_r == cas_pkg::FN_RELEASE) begin
        if (sel_cnt <= cas_pkg::CNT_W'(1)) begin
          valid_nxt[sel_idx] = 1'b0;
          used_nxt           = used_r - UW'(1);
        end else begin
          tw_en  = 1'b1;
          tw_cnt = sel_cnt - cas_pkg::CNT_W'(1);
        end
      end else if (sel_hit) begin
        tw_en  = 1'b1;
        tw_cnt = sel_cnt + cas_pkg::CNT_W'(sel_add);
      end else begin
        tw_en               = 1'b1;
        tw_idx              = free_idx;
        tw_cnt              = cas_pkg::CNT_W'(sel_add);
        valid_nxt[free_idx] = 1'b1;
        used_nxt            = used_r + UW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      id_r[tw_idx]  <= ids_r[slot_r];
      cnt_r[tw_idx] <= tw_cnt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        slot_nxt  = '0;
        state_nxt = applies ? S_COMMIT : S_IDLE;
      end
      S_COMMIT: begin
        slot_nxt = slot_r + cas_pkg::SLOT_W'(1);
        if (last_slot) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      valid_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      valid_r     <= valid_nxt;
      used_r      <= used_nxt;
      out_valid_r <= (state_r == S_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EVAL) out_r <= verdict;
  end

  assign out_valid      = out_valid_r;
  assign out_granted    = out_r.granted;
  assign out_status     = out_r.status;
  assign out_fault_slot = out_r.fault_slot;

`ifndef SYNTHESIS
  // occupancy counter tracks the valid bits
  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    used_r == UW'($countones(valid_r)))
    else $error("used count out of step with valid bits");

  // a strobe only follows an evaluate cycle
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EVAL))
    else $error("result strobe without evaluation");

  // a release being applied always finds its entry
  a_rel_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && func_r == cas_pkg::FN_RELEASE) |-> sel_hit)
    else $error("release commit missed the table");

  // a new entry during acquire always has room
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && func_r == cas_pkg::FN_ACQUIRE && !sel_hit) |-> !(&valid_r))
    else $error("acquire commit with a full table");
`endif

endmodule

// ===== src/cas_lane.sv =====
// ----------------------------------------------------------------------------
// cas_lane: one slot's associative lookup
// Compares one resource ID against every table entry and returns the lowest
// matching entry, its index and its reader count.
// ----------------------------------------------------------------------------
module cas_lane #(
  parameter int TABLE_ENTRIES = cas_pkg::TABLE_ENTRIES_DEF,
  parameter int ID_BITS       = cas_pkg::ID_BITS_DEF,
  localparam int IDX_W        = $clog2(TABLE_ENTRIES)
) (
  input  logic [ID_BITS-1:0]       id,
  input  logic [TABLE_ENTRIES-1:0] tbl_valid,
  input  logic [ID_BITS-1:0]       tbl_id  [TABLE_ENTRIES],
  input  logic [cas_pkg::CNT_W-1:0] tbl_cnt [TABLE_ENTRIES],
  output cas_pkg::lane_res_t       res,
  output logic [IDX_W-1:0]         idx
);

  logic [TABLE_ENTRIES-1:0] match;
  logic [TABLE_ENTRIES-1:0] first;

  always_comb begin
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      match[e] = tbl_valid[e] && (tbl_id[e] == id);
    end
  end

  // isolate lowest set bit
  assign first = match & (~match + TABLE_ENTRIES'(1));

  always_comb begin
    idx     = '0;
    res.cnt = '0;
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      if (first[e]) begin
        idx     = idx | IDX_W'(e);
        res.cnt = res.cnt | tbl_cnt[e];
      end
    end
    res.hit = |match;
  end

endmodule

// ===== src/cas_merge.sv =====
// ----------------------------------------------------------------------------
// cas_merge: combine lane lookups into one verdict
// Handles repeated IDs inside a word, conflict, room and saturation checks, release
// checks, and picks the lowest faulting slot.
// ----------------------------------------------------------------------------
module cas_merge #(
  parameter int TABLE_ENTRIES = cas_pkg::TABLE_ENTRIES_DEF,
  parameter int ID_BITS       = cas_pkg::ID_BITS_DEF,
  localparam int UW           = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic [cas_pkg::FUNC_W-1:0]  func,
  input  logic [cas_pkg::SCNT_W-1:0]  n,
  input  logic [ID_BITS-1:0]          ids  [cas_pkg::SLOTS],
  input  logic [cas_pkg::SLOTS-1:0]   wr,
  input  cas_pkg::lane_res_t          lane [cas_pkg::SLOTS],
  input  logic [UW-1:0]               used,
  output cas_pkg::verdict_t           verdict
);

  localparam int S     = cas_pkg::SLOTS;
  localparam int CUM_W = cas_pkg::CNT_W + 2;

  logic [S-1:0]                act;
  logic [S-1:0]                fresh;
  logic [cas_pkg::SCNT_W-1:0]  rank   [S];
  logic [cas_pkg::SCNT_W-1:0]  rd_cnt [S];
  logic [cas_pkg::SCNT_W-1:0]  rl_cnt [S];
  logic [S-1:0]                f_conf;
  logic [S-1:0]                f_room;
  logic [S-1:0]                f_rel;
  logic [S-1:0]                fault;
  logic [S-1:0]                low;
  logic [cas_pkg::STAT_W-1:0]  code;

  always_comb begin
    for (int k = 0; k < S; k++) begin
      act[k] = (cas_pkg::SCNT_W'(k) < n);
    end
  end

  // per-slot counts over this and earlier slots of the same word
  always_comb begin
    logic seen;
    for (int k = 0; k < S; k++) begin
      seen      = 1'b0;
      rank[k]   = '0;
      rd_cnt[k] = '0;
      rl_cnt[k] = '0;
      for (int j = 0; j < S; j++) begin
        if (j < k && act[j] && ids[j] == ids[k]) seen = 1'b1;
        if (j <= k && act[j] && ids[j] == ids[k]) begin
          rl_cnt[k] = rl_cnt[k] + cas_pkg::SCNT_W'(1);
          if (!wr[j]) rd_cnt[k] = rd_cnt[k] + cas_pkg::SCNT_W'(1);
        end
      end
      fresh[k] = act[k] && !lane[k].hit && !seen;
    end
    for (int k = 0; k < S; k++) begin
      for (int j = 0; j < S; j++) begin
        if (j < k && fresh[j]) rank[k] = rank[k] + cas_pkg::SCNT_W'(1);
      end
    end
  end

  always_comb begin
    logic [CUM_W-1:0]         cum;
    logic [cas_pkg::CNT_W-1:0] allow;
    for (int k = 0; k < S; k++) begin
      f_conf[k] = act[k] && lane[k].hit && (wr[k] || lane[k].cnt == '0);
      cum = (lane[k].hit ? CUM_W'(lane[k].cnt) : '0) + CUM_W'(rd_cnt[k]);
      f_room[k] = (fresh[k] && ((UW + 1)'(used) + (UW + 1)'(rank[k])
                               >= (UW + 1)'(TABLE_ENTRIES)))
               || (act[k] && !wr[k] && cum > CUM_W'(cas_pkg::CNT_MAX));
      allow = (lane[k].cnt == '0) ? cas_pkg::CNT_W'(1) : lane[k].cnt;
      f_rel[k] = act[k] && (!lane[k].hit
               || cas_pkg::CNT_W'(rl_cnt[k]) > allow);
    end
  end

  always_comb begin
    case (func)
      cas_pkg::FN_RELEASE: begin
        fault = f_rel;
        code  = cas_pkg::ST_NOTHELD;
      end
      cas_pkg::FN_ACQUIRE: begin
        fault = (|f_conf) ? f_conf : f_room;
        code  = (|f_conf) ? cas_pkg::ST_CONFLICT : cas_pkg::ST_NOROOM;
      end
      default: begin
        fault = f_conf;
        code  = cas_pkg::ST_CONFLICT;
      end
    endcase
  end

  assign low = fault & (~fault + S'(1));

  always_comb begin
    verdict.fault_slot = '0;
    for (int k = 0; k < S; k++) begin
      if (low[k]) verdict.fault_slot = verdict.fault_slot | cas_pkg::FSLOT_W'(k);
    end
    verdict.granted = ~|fault;
    verdict.status  = (|fault) ? code : cas_pkg::ST_OK;
  end

endmodule
